/* rtl/podi_pkg.sv */
// Shared constants, types and the arctangent table of the planar odometry integrator.
package podi_pkg;

    // CORDIC setup
    localparam int CORDIC_ITERATIONS = 14;
    localparam int ATAN_LEN          = 24;
    localparam int CORDIC_N          = (CORDIC_ITERATIONS < ATAN_LEN) ?
                                       CORDIC_ITERATIONS : ATAN_LEN;
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_N - 1);

    // Q5.30 angle during reduction, and CORDIC datapath word
    typedef logic signed [35:0] angle_t;
    typedef logic signed [33:0] cs_t;

    localparam angle_t PI_Q30          = 36'sd3373259426;
    localparam angle_t NEG_PI_Q30      = -36'sd3373259426;
    localparam angle_t TWO_PI_Q30      = 36'sd6746518852;
    localparam angle_t HALF_PI_Q30     = 36'sd1686629713;
    localparam angle_t NEG_HALF_PI_Q30 = -36'sd1686629713;
    localparam cs_t    GAIN_Q30        = 34'sd652032874;

    // Heading wrap in Q3.12
    localparam logic signed [33:0] PI_Q12     = 34'sd12868;
    localparam logic signed [33:0] NEG_PI_Q12 = -34'sd12868;
    localparam logic signed [33:0] TWO_PI_Q12 = 34'sd25736;
    localparam logic signed [33:0] HEAD_MAX   = 34'sd32767;
    localparam logic signed [33:0] HEAD_MIN   = -34'sd32768;

    // Rounding offsets and divisors
    localparam logic signed [49:0] RND_RATE    = 50'sd131072;
    localparam logic signed [63:0] RND_STEP    = 64'sd8000;
    localparam logic signed [63:0] RND_HEADING = 64'sd500;
    localparam int DEN_W = 14;
    localparam logic [DEN_W-1:0] DEN_STEP    = 14'd16000;
    localparam logic [DEN_W-1:0] DEN_HEADING = 14'd1000;

    // Divider: quotient bits resolved per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = 32 / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

    // Configuration register indexes
    localparam logic [7:0] CFG_DEFAULT_STEP = 8'd0;
    localparam logic [7:0] CFG_MAX_GAP      = 8'd1;

    // Truncated Q2.30 arctangent of 2^-i
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h3243F6A8;
            5'd1:    val = 32'h1DAC6705;
            5'd2:    val = 32'h0FADBAFC;
            5'd3:    val = 32'h07F56EA6;
            5'd4:    val = 32'h03FEAB76;
            5'd5:    val = 32'h01FFD55B;
            5'd6:    val = 32'h00FFFAAA;
            5'd7:    val = 32'h007FFF55;
            5'd8:    val = 32'h003FFFEA;
            5'd9:    val = 32'h001FFFFD;
            5'd10:   val = 32'h000FFFFF;
            5'd11:   val = 32'h0007FFFF;
            5'd12:   val = 32'h0003FFFF;
            5'd13:   val = 32'h0001FFFF;
            5'd14:   val = 32'h0000FFFF;
            5'd15:   val = 32'h00007FFF;
            5'd16:   val = 32'h00003FFF;
            5'd17:   val = 32'h00001FFF;
            5'd18:   val = 32'h00000FFF;
            5'd19:   val = 32'h000007FF;
            5'd20:   val = 32'h000003FF;
            5'd21:   val = 32'h000001FF;
            5'd22:   val = 32'h000000FF;
            5'd23:   val = 32'h0000007F;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

/* rtl/planar_odometry_integrator_core.sv */
// Top level of the planar odometry integrator: sequencer, shared multiplier and pose state.
//
//  channel | dir | handshake               | payload
//  s_      | in  | s_tvalid / s_tready     | s_tdata  80 bit: stamp, vel_x, vel_y, yaw_rate
//  m_      | out | m_tvalid / m_tready     | m_tdata 176 bit: pose, heading, increments
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_index 8 bit, cfg_data 16 bit
//
// An item runs from accept to result through the CORDIC rotations, the one shared 34x32
// multiplier and three passes of the 4-bit-per-cycle divider. s_tready is high only while
// the sequencer idles.
// A finished result sits in the output register; the next item is accepted while it waits,
// and the sequencer stalls at its end only if the previous result is still not taken.
// aresetn is synchronous; it clears the pose, the stamp state and the registers to defaults.
// cfg_ready is always high.
module planar_odometry_integrator_core import podi_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // time_stamp, vel_x, vel_y, yaw_rate
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata,   // pose_x, pose_y, heading, step_x, step_y, step_heading
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CORDIC = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_DGO    = 7'b0001000,
        S_DWAIT  = 7'b0010000,
        S_SUM    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    // Multiplier schedule slots
    localparam logic [2:0] MS_XC  = 3'd0;
    localparam logic [2:0] MS_YS  = 3'd1;
    localparam logic [2:0] MS_XS  = 3'd2;
    localparam logic [2:0] MS_YC  = 3'd3;
    localparam logic [2:0] MS_NX  = 3'd4;
    localparam logic [2:0] MS_NY  = 3'd5;
    localparam logic [2:0] MS_NH  = 3'd6;
    localparam logic [2:0] MS_END = 3'd7;

    // Divider jobs
    localparam logic [1:0] DIV_X = 2'd0;
    localparam logic [1:0] DIV_Y = 2'd1;
    localparam logic [1:0] DIV_H = 2'd2;

    state_t             state_reg;
    logic [9:0]         default_step_reg;
    logic [15:0]        max_gap_reg;
    logic signed [31:0] kept_x_reg, kept_y_reg;
    logic signed [15:0] kept_head_reg;
    logic [31:0]        last_stamp_reg;
    logic               started_reg;
    logic signed [15:0] vx_reg, vy_reg, wz_reg;
    logic signed [31:0] dt_reg;
    logic [2:0]         mul_cnt_reg;
    logic signed [65:0] prod_reg;
    logic signed [49:0] acc_reg;
    cs_t                r20x_reg, r20y_reg;
    logic signed [63:0] nx_reg, ny_reg, nh_reg;
    logic [1:0]         div_cnt_reg;
    logic signed [31:0] sx_reg, sy_reg, sh_reg;
    logic signed [32:0] px_sum_reg, py_sum_reg, h_sum_reg;
    logic               m_valid_reg;
    logic [175:0]       m_data_reg;

    logic               accept;
    logic [31:0]        stamp_diff;
    logic               gap_ok;
    logic signed [31:0] dt_next;
    logic               cordic_done;
    cs_t                cos_q30, sin_q30;
    cs_t                mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] prod_next;
    logic signed [49:0] rate_diff, rate_sum;
    logic               div_start, div_done;
    logic signed [63:0] div_num;
    logic [DEN_W-1:0]   div_den;
    logic signed [31:0] div_quo;
    logic signed [31:0] px_sat, py_sat;
    logic signed [33:0] h_wide, h_wrap;
    logic signed [15:0] head_sat;
    logic               load_out;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Time step: real stamp gap once started and at most max_gap (signed compare), else the default
    always_comb begin
        stamp_diff = s_tdata[31:0] - last_stamp_reg;
        gap_ok     = started_reg &&
                     ($signed({stamp_diff[31], stamp_diff}) <= $signed({17'b0, max_gap_reg}));
        dt_next    = gap_ok ? $signed(stamp_diff) : $signed({22'b0, default_step_reg});
    end

    podi_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .head    (kept_head_reg),
        .done    (cordic_done),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    // Shared multiplier operand select
    always_comb begin
        unique case (mul_cnt_reg)
            MS_XC: begin
                mul_a = cos_q30;
                mul_b = $signed({{16{vx_reg[15]}}, vx_reg});
            end
            MS_YS: begin
                mul_a = sin_q30;
                mul_b = $signed({{16{vy_reg[15]}}, vy_reg});
            end
            MS_XS: begin
                mul_a = sin_q30;
                mul_b = $signed({{16{vx_reg[15]}}, vx_reg});
            end
            MS_YC: begin
                mul_a = cos_q30;
                mul_b = $signed({{16{vy_reg[15]}}, vy_reg});
            end
            MS_NX: begin
                mul_a = r20x_reg;
                mul_b = dt_reg;
            end
            MS_NY: begin
                mul_a = r20y_reg;
                mul_b = dt_reg;
            end
            default: begin
                mul_a = $signed({{18{wz_reg[15]}}, wz_reg});
                mul_b = dt_reg;
            end
        endcase
        prod_next = mul_a * mul_b;
        rate_diff = acc_reg - $signed(prod_reg[49:0]);
        rate_sum  = acc_reg + $signed(prod_reg[49:0]);
    end

    // Divider job select
    always_comb begin
        unique case (div_cnt_reg)
            DIV_X:   div_num = nx_reg;
            DIV_Y:   div_num = ny_reg;
            default: div_num = nh_reg;
        endcase
        div_den   = (div_cnt_reg == DIV_H) ? DEN_HEADING : DEN_STEP;
        div_start = (state_reg == S_DGO);
    end

    podi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Pose saturation and heading wrap
    always_comb begin
        if (px_sum_reg[32] != px_sum_reg[31]) begin
            px_sat = px_sum_reg[32] ? INT32_MIN : INT32_MAX;
        end else begin
            px_sat = px_sum_reg[31:0];
        end
        if (py_sum_reg[32] != py_sum_reg[31]) begin
            py_sat = py_sum_reg[32] ? INT32_MIN : INT32_MAX;
        end else begin
            py_sat = py_sum_reg[31:0];
        end
        h_wide = $signed({h_sum_reg[32], h_sum_reg});
        if (h_wide < NEG_PI_Q12) begin
            h_wrap = h_wide + TWO_PI_Q12;
        end else if (h_wide > PI_Q12) begin
            h_wrap = h_wide - TWO_PI_Q12;
        end else begin
            h_wrap = h_wide;
        end
        if (h_wrap > HEAD_MAX) begin
            head_sat = 16'sh7FFF;
        end else if (h_wrap < HEAD_MIN) begin
            head_sat = 16'sh8000;
        end else begin
            head_sat = h_wrap[15:0];
        end
        load_out = (state_reg == S_OUT) && (!m_valid_reg || m_tready);
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_step_reg <= 10'd100;
            max_gap_reg      <= 16'd1000;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_DEFAULT_STEP) begin
                default_step_reg <= cfg_data[9:0];
            end else if (cfg_index == CFG_MAX_GAP) begin
                max_gap_reg <= cfg_data;
            end
        end
    end

    // Main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            kept_x_reg     <= '0;
            kept_y_reg     <= '0;
            kept_head_reg  <= '0;
            last_stamp_reg <= '0;
            started_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        vx_reg         <= $signed(s_tdata[47:32]);
                        vy_reg         <= $signed(s_tdata[63:48]);
                        wz_reg         <= $signed(s_tdata[79:64]);
                        dt_reg         <= dt_next;
                        last_stamp_reg <= s_tdata[31:0];
                        started_reg    <= 1'b1;
                        state_reg      <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (cordic_done) begin
                        mul_cnt_reg <= MS_XC;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL: begin
                    // product of the previous slot is consumed here
                    prod_reg    <= prod_next;
                    mul_cnt_reg <= mul_cnt_reg + 3'd1;
                    unique case (mul_cnt_reg)
                        MS_YS: acc_reg  <= $signed(prod_reg[49:0]) + RND_RATE;
                        MS_XS: r20x_reg <= $signed({{2{rate_diff[49]}}, rate_diff[49:18]});
                        MS_YC: acc_reg  <= $signed(prod_reg[49:0]) + RND_RATE;
                        MS_NX: r20y_reg <= $signed({{2{rate_sum[49]}}, rate_sum[49:18]});
                        MS_NY: nx_reg   <= $signed(prod_reg[63:0]) + RND_STEP;
                        MS_NH: ny_reg   <= $signed(prod_reg[63:0]) + RND_STEP;
                        MS_END: begin
                            nh_reg      <= $signed(prod_reg[63:0]) + RND_HEADING;
                            div_cnt_reg <= DIV_X;
                            state_reg   <= S_DGO;
                        end
                        default: ;
                    endcase
                end
                S_DGO: begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        unique case (div_cnt_reg)
                            DIV_X:   sx_reg <= div_quo;
                            DIV_Y:   sy_reg <= div_quo;
                            default: sh_reg <= div_quo;
                        endcase
                        if (div_cnt_reg == DIV_H) begin
                            state_reg <= S_SUM;
                        end else begin
                            div_cnt_reg <= div_cnt_reg + 2'd1;
                            state_reg   <= S_DGO;
                        end
                    end
                end
                S_SUM: begin
                    px_sum_reg <= {kept_x_reg[31], kept_x_reg} + {sx_reg[31], sx_reg};
                    py_sum_reg <= {kept_y_reg[31], kept_y_reg} + {sy_reg[31], sy_reg};
                    h_sum_reg  <= {{17{kept_head_reg[15]}}, kept_head_reg}
                                  + {sh_reg[31], sh_reg};
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (load_out) begin
                        kept_x_reg    <= px_sat;
                        kept_y_reg    <= py_sat;
                        kept_head_reg <= head_sat;
                        m_data_reg    <= {sh_reg, sy_reg, sx_reg, head_sat, py_sat, px_sat};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_cordic_in_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == S_CORDIC))
        else $error("CORDIC finished outside its phase");

    a_div_in_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DWAIT))
        else $error("divider finished while not awaited");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output phase");
`endif

endmodule

/* rtl/podi_cordic.sv */
// Iterative CORDIC: cosine and sine of a Q3.12 heading, one rotation per cycle.
module podi_cordic import podi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] head,
    output logic               done,
    output cs_t                cos_q30,
    output cs_t                sin_q30
);

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_RED  = 5'b00010,
        C_FOLD = 5'b00100,
        C_ITER = 5'b01000,
        C_OUT  = 5'b10000
    } cstate_t;

    cstate_t     state_reg;
    angle_t      ang_reg;
    logic        red_cnt_reg;
    logic        flip_reg;
    cs_t         x_reg, y_reg, z_reg;
    logic [4:0]  iter_reg;
    cs_t         cos_reg, sin_reg;
    logic        done_reg;

    cs_t x_sh, y_sh, atan_val;

    // Floor shifts and table value for the current rotation
    always_comb begin
        x_sh     = x_reg >>> iter_reg;
        y_sh     = y_reg >>> iter_reg;
        atan_val = $signed({2'b00, atan_q30(iter_reg)});
    end

    // Sequencer: two wrap passes, quadrant fold, rotations, sign fix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        ang_reg     <= angle_t'(head) <<< 18;
                        red_cnt_reg <= 1'b0;
                        state_reg   <= C_RED;
                    end
                end
                C_RED: begin
                    if (ang_reg > PI_Q30) begin
                        ang_reg <= ang_reg - TWO_PI_Q30;
                    end else if (ang_reg < NEG_PI_Q30) begin
                        ang_reg <= ang_reg + TWO_PI_Q30;
                    end
                    red_cnt_reg <= 1'b1;
                    if (red_cnt_reg) begin
                        state_reg <= C_FOLD;
                    end
                end
                C_FOLD: begin
                    if (ang_reg > HALF_PI_Q30) begin
                        z_reg    <= 34'(ang_reg - PI_Q30);
                        flip_reg <= 1'b1;
                    end else if (ang_reg < NEG_HALF_PI_Q30) begin
                        z_reg    <= 34'(ang_reg + PI_Q30);
                        flip_reg <= 1'b1;
                    end else begin
                        z_reg    <= 34'(ang_reg);
                        flip_reg <= 1'b0;
                    end
                    x_reg     <= GAIN_Q30;
                    y_reg     <= '0;
                    iter_reg  <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER: begin
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - atan_val;
                    end else begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + atan_val;
                    end
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == CORDIC_LAST) begin
                        state_reg <= C_OUT;
                    end
                end
                C_OUT: begin
                    cos_reg   <= flip_reg ? -x_reg : x_reg;
                    sin_reg   <= flip_reg ? -y_reg : y_reg;
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

/* rtl/podi_div.sv */
// Floor division of a signed numerator by a small constant divisor, saturated to 32 bits.
module podi_div import podi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic signed [31:0] quo
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg, ovf_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [31:0]          lo_reg;
    logic [31:0]          q_reg;
    logic signed [31:0]   quo_reg;
    logic                 done_reg;

    logic [63:0]          mag;
    logic                 ovf_start;
    logic [DEN_W:0]       trial;
    logic [DEN_W-1:0]     rem_next;
    logic [DIV_STEPS-1:0] qbits;
    logic [31:0]          q_next;
    logic signed [31:0]   quo_next;

    // Negative numerators divide their complement: floor(n/d) = ~(~n / d)
    always_comb begin
        mag       = num[63] ? ~num : num;
        ovf_start = mag[63:31] >= 33'(den);
    end

    // Restoring long division, several quotient bits per cycle
    always_comb begin
        rem_next = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {rem_next, lo_reg[31-j]};
            if (trial >= {1'b0, den_reg}) begin
                rem_next               = DEN_W'(trial - {1'b0, den_reg});
                qbits[DIV_STEPS-1-j] = 1'b1;
            end else begin
                rem_next = trial[DEN_W-1:0];
            end
        end
        q_next = {q_reg[31-DIV_STEPS:0], qbits};
        if (ovf_reg) begin
            quo_next = neg_reg ? INT32_MIN : INT32_MAX;
        end else begin
            quo_next = neg_reg ? $signed(~q_next) : $signed(q_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                neg_reg  <= num[63];
                ovf_reg  <= ovf_start;
                den_reg  <= den;
                rem_reg  <= mag[32+DEN_W-1:32];
                lo_reg   <= mag[31:0];
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                lo_reg  <= lo_reg << DIV_STEPS;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quo_reg  <= quo_next;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
